/* rtl/core/tlg_pkg.sv */
// Shared types and constants of the toroidal Life grid engine.
// No dependencies; every other file of the block but tlg_ram refers to it by scoped names.
`default_nettype none

package tlg_pkg;

  // Grid storage size.
  localparam int ROWS = 64;
  localparam int COLS = 128;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  // Widths of the area registers and the generation step counter.
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 8;
  localparam int STEP_W = $clog2(ROWS + 4);

  // Reset values of the area registers.
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(40);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(120);

  // Life rule: birth on exactly three neighbors, survival on two or three.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_STEP  = 2'd2
  } func_e;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // The three grid rows of one column as held by a column cell.
  typedef struct packed {
    logic above;
    logic cur;
    logic below;
  } col_t;

endpackage : tlg_pkg

`default_nettype wire

/* rtl/core/tlg_ram.sv */
// Generic single-write, single-read RAM with bit write mask and registered read.
// No dependencies.
`default_nettype none

module tlg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_mask_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wr_mask_i[i]) begin
          mem[wr_addr_i][i] <= wr_data_i[i];
        end
      end
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule : tlg_ram

`default_nettype wire

/* rtl/core/tlg_cell.sv */
// One column cell of the Life engine: holds three rows of its column; in the
// area applies B3/S23 with both neighbors, else keeps its cell. Uses tlg_pkg.
`default_nettype none

module tlg_cell (
  input  wire logic          clk_i,
  input  wire logic          shift_en_i,
  input  wire logic          shift_in_i,
  input  wire logic          in_area_i,
  input  wire tlg_pkg::col_t left_i,
  input  wire tlg_pkg::col_t right_i,
  output tlg_pkg::col_t      col_o,
  output logic               next_o
);

  tlg_pkg::col_t col_q;
  logic [3:0]    count;

  // Rows move up through the column window: the newest row enters as below.
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      col_q.above <= col_q.cur;
      col_q.cur   <= col_q.below;
      col_q.below <= shift_in_i;
    end
  end

  always_comb begin
    count = 4'(left_i.above) + 4'(left_i.cur) + 4'(left_i.below)
          + 4'(col_q.above) + 4'(col_q.below)
          + 4'(right_i.above) + 4'(right_i.cur) + 4'(right_i.below);
    if (in_area_i) begin
      next_o = (count == tlg_pkg::BIRTH_COUNT)
            || (col_q.cur && (count == tlg_pkg::SURVIVE_COUNT));
    end else begin
      next_o = col_q.cur;
    end
  end

  assign col_o = col_q;

endmodule : tlg_cell

`default_nettype wire

/* rtl/core/toroidal_life_grid_engine.sv */
// Toroidal Life grid engine (B3/S23 on a wrapped grid), top level; uses tlg_pkg, tlg_ram, tlg_cell.
// A cell write or an unused code gives its result word in the cycle after acceptance;
// a cell read goes through the RAM read register and then the result register; a
// generation walks one row a cycle through the single RAM read port.
// One word is in flight at a time: the next input word is taken as the result word leaves.
// Reset clears control, loads 40 rows and 120 columns, and clears the row valid flags.
`default_nettype none

module toroidal_life_grid_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: func[1:0], cell_row[7:2], cell_col[14:8], cell_value[15].
  input  wire logic [15:0] s_axis_tdata,
  // Result words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: cell_alive[0], zero fill [7:1].
  output logic      [7:0]  m_axis_tdata,
  // Configuration writes: index 0 is rows_in_use, index 1 is cols_in_use.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int ROWS   = tlg_pkg::ROWS;
  localparam int COLS   = tlg_pkg::COLS;
  localparam int ROW_W  = tlg_pkg::ROW_W;
  localparam int COL_W  = tlg_pkg::COL_W;
  localparam int STEP_W = tlg_pkg::STEP_W;

  // The sequencer: idle, waiting on the RAM for a read, or walking a generation.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK
  } state_e;

  state_e                              state_q, state_d;
  logic [STEP_W-1:0]                   step_q, step_d;
  logic                                out_valid_q, out_valid_d;
  logic                                out_alive_q, out_alive_d;
  logic [COL_W-1:0]                    rd_col_q, rd_col_d;
  logic                                rd_vld_q, rd_vld_d;
  logic [COLS-1:0]                     first_q, first_d;
  logic [ROWS-1:0]                     valid_q, valid_d;
  logic [tlg_pkg::ROWS_CFG_W-1:0]      rows_q, rows_d;
  logic [tlg_pkg::COLS_CFG_W-1:0]      cols_q, cols_d;

  // Input word fields.
  logic [1:0]       in_func;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_value;
  logic             in_fire;

  assign in_func  = s_axis_tdata[1:0];
  assign in_row   = s_axis_tdata[7:2];
  assign in_col   = s_axis_tdata[14:8];
  assign in_value = s_axis_tdata[15];

  // Active area, clamped: zero acts as one, anything beyond storage as the full size.
  logic [ROW_W-1:0]  nr_m1;
  logic [COL_W-1:0]  nc_m1;
  logic [STEP_W-1:0] nr;

  always_comb begin
    if (rows_q == '0) begin
      nr_m1 = '0;
    end else if (rows_q > tlg_pkg::ROWS_CFG_W'(ROWS)) begin
      nr_m1 = ROW_W'(ROWS - 1);
    end else begin
      nr_m1 = ROW_W'(rows_q - tlg_pkg::ROWS_CFG_W'(1));
    end
    if (cols_q == '0) begin
      nc_m1 = '0;
    end else if (cols_q > tlg_pkg::COLS_CFG_W'(COLS)) begin
      nc_m1 = COL_W'(COLS - 1);
    end else begin
      nc_m1 = COL_W'(cols_q - tlg_pkg::COLS_CFG_W'(1));
    end
    nr = STEP_W'(nr_m1) + STEP_W'(1);
  end

  // Grid row storage and its ports.
  logic             ram_wr_en;
  logic [ROW_W-1:0] ram_wr_addr;
  logic [COLS-1:0]  ram_wr_mask;
  logic [COLS-1:0]  ram_wr_data;
  logic             ram_rd_en;
  logic [ROW_W-1:0] ram_rd_addr;
  logic [COLS-1:0]  ram_rd_data;
  logic [COLS-1:0]  rd_masked;

  tlg_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_mask_i (ram_wr_mask),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // A row that was never written since reset reads as all dead.
  assign rd_masked = ram_rd_data & {COLS{rd_vld_q}};

  // Chain of column cells. Each cell sees its neighbors' three-row windows;
  // the leftmost and the last active column wrap around to each other.
  logic             shift_en;
  logic [COLS-1:0]  shift_row;
  logic [COLS-1:0]  next_row;
  tlg_pkg::col_t    col_bus [COLS];

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    tlg_pkg::col_t left_col;
    tlg_pkg::col_t right_col;

    if (c == 0) begin : g_left_wrap
      assign left_col = col_bus[nc_m1];
    end else begin : g_left
      assign left_col = col_bus[c-1];
    end

    if (c == COLS - 1) begin : g_right_wrap
      assign right_col = col_bus[0];
    end else begin : g_right
      assign right_col = (nc_m1 == COL_W'(c)) ? col_bus[0] : col_bus[c+1];
    end

    tlg_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en),
      .shift_in_i (shift_row[c]),
      .in_area_i  (COL_W'(c) <= nc_m1),
      .left_i     (left_col),
      .right_i    (right_col),
      .col_o      (col_bus[c]),
      .next_o     (next_row[c])
    );
  end

  // Input is taken only when idle and the result register will be free.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Next-state logic. A generation walk runs step 0 up to rows + 3:
  //   steps 0 .. rows      read last row, then rows 0 .. last (old contents);
  //   steps 1 .. rows + 2  shift a row into the cells, the last one being the
  //                        saved old row 0 as the wrapped neighbor of the last row;
  //   steps 4 .. rows + 3  write back new row (step - 4) from the cells.
  // A row is always read before its new value is written.
  always_comb begin
    logic [COLS-1:0]  bit_mask;
    logic [ROW_W-1:0] walk_addr;

    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_alive_d = out_alive_q;
    rd_col_d    = rd_col_q;
    rd_vld_d    = rd_vld_q;
    first_d     = first_q;
    valid_d     = valid_q;
    rows_d      = rows_q;
    cols_d      = cols_q;

    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_mask = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    shift_en    = 1'b0;
    shift_row   = '0;

    bit_mask  = COLS'(1) << in_col;
    walk_addr = (step_q == '0) ? nr_m1 : ROW_W'(step_q - STEP_W'(1));

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tlg_pkg::CFG_ROWS: rows_d = cfg_data_i[tlg_pkg::ROWS_CFG_W-1:0];
        tlg_pkg::CFG_COLS: cols_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_func)
            tlg_pkg::FUNC_WRITE: begin
              // A row never written gets written whole, so its other cells read dead.
              ram_wr_en   = 1'b1;
              ram_wr_addr = in_row;
              ram_wr_mask = valid_q[in_row] ? bit_mask : '1;
              ram_wr_data = in_value ? bit_mask : '0;
              valid_d[in_row] = 1'b1;
              out_valid_d = 1'b1;
              out_alive_d = 1'b0;
            end
            tlg_pkg::FUNC_READ: begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = in_row;
              rd_vld_d    = valid_q[in_row];
              rd_col_d    = in_col;
              state_d     = ST_READ;
            end
            tlg_pkg::FUNC_STEP: begin
              step_d  = '0;
              state_d = ST_WALK;
            end
            default: begin
              out_valid_d = 1'b1;
              out_alive_d = 1'b0;
            end
          endcase
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        out_alive_d = rd_masked[rd_col_q];
        state_d     = ST_IDLE;
      end

      ST_WALK: begin
        step_d = step_q + STEP_W'(1);
        if (step_q <= nr) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = walk_addr;
          rd_vld_d    = valid_q[walk_addr];
        end
        if ((step_q >= STEP_W'(1)) && (step_q <= nr + STEP_W'(2))) begin
          shift_en  = 1'b1;
          shift_row = (step_q <= nr + STEP_W'(1)) ? rd_masked : first_q;
        end
        if (step_q == STEP_W'(2)) begin
          first_d = rd_masked;
        end
        if (step_q >= STEP_W'(4)) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ROW_W'(step_q - STEP_W'(4));
          ram_wr_mask = '1;
          ram_wr_data = next_row;
          valid_d[ROW_W'(step_q - STEP_W'(4))] = 1'b1;
        end
        if (step_q == nr + STEP_W'(3)) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_alive_d = 1'b0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_alive_q <= 1'b0;
      rd_col_q    <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= '0;
      valid_q     <= '0;
      rows_q      <= tlg_pkg::ROWS_RESET;
      cols_q      <= tlg_pkg::COLS_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_alive_q <= out_alive_d;
      rd_col_q    <= rd_col_d;
      rd_vld_q    <= rd_vld_d;
      first_q     <= first_d;
      valid_q     <= valid_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_alive_q};

endmodule : toroidal_life_grid_engine

`default_nettype wire

/* test/tlg_grid_checker.sv */
// Result checker for the toroidal Life grid engine: it watches the input, result and
// configuration channels, predicts every result word and compares its cell_alive bit.
// Depends on tlg_pkg only.
module tlg_grid_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  // From bit 0: func[1:0], cell_row[7:2], cell_col[14:8], cell_value[15].
  input  wire logic [15:0] in_word_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  // From bit 0: cell_alive[0], zero fill [7:1].
  input  wire logic [7:0]  out_word_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  output int               mismatch_count_o,
  output int               outstanding_o
);

  typedef struct {
    logic       alive;
    logic [1:0] func;
    logic [5:0] row;
    logic [6:0] col;
  } alive_expect_t;

  logic [tlg_pkg::COLS-1:0]       grid_q [tlg_pkg::ROWS];
  logic [tlg_pkg::ROWS_CFG_W-1:0] rows_cfg;
  logic [tlg_pkg::COLS_CFG_W-1:0] cols_cfg;
  alive_expect_t                  alive_expected_q [$];

  initial mismatch_count_o = 0;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  // A zero area register acts as one, and one above storage acts as the storage size.
  function automatic int span_of(int raw, int storage);
    if (raw == 0) return 1;
    if (raw > storage) return storage;
    return raw;
  endfunction

  // One generation over the active area. Every cell is judged on the old grid, so the
  // update is simultaneous; with one row or column a cell meets itself as a neighbor.
  task automatic evolve_grid();
    logic [tlg_pkg::COLS-1:0] old_grid [tlg_pkg::ROWS];
    int nr, nc, n, r, c, dr, dc;
    old_grid = grid_q;
    nr = span_of(int'(rows_cfg), tlg_pkg::ROWS);
    nc = span_of(int'(cols_cfg), tlg_pkg::COLS);
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += int'(old_grid[(r + dr + nr) % nr][(c + dc + nc) % nc]);
            end
          end
        end
        if (old_grid[r][c]) begin
          grid_q[r][c] = (n == tlg_pkg::SURVIVE_COUNT) || (n == tlg_pkg::BIRTH_COUNT);
        end else begin
          grid_q[r][c] = (n == tlg_pkg::BIRTH_COUNT);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    alive_expect_t want;
    int r;
    if (!rst_ni) begin
      for (r = 0; r < tlg_pkg::ROWS; r++) begin
        grid_q[r] = '0;
      end
      rows_cfg = tlg_pkg::ROWS_RESET;
      cols_cfg = tlg_pkg::COLS_RESET;
      alive_expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tlg_pkg::CFG_ROWS) begin
          rows_cfg = cfg_data_i[tlg_pkg::ROWS_CFG_W-1:0];
        end else begin
          cols_cfg = cfg_data_i[tlg_pkg::COLS_CFG_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (alive_expected_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", out_word_i));
        end else begin
          want = alive_expected_q.pop_front();
          if (out_word_i[0] !== want.alive) begin
            report_mismatch($sformatf("cell_alive %b, expected %b (func %0d row %0d col %0d)",
                                      out_word_i[0], want.alive, want.func, want.row,
                                      want.col));
          end
        end
      end
      // The field widths keep every address inside storage.
      if (in_valid_i && in_ready_i) begin
        want.func  = in_word_i[1:0];
        want.row   = in_word_i[7:2];
        want.col   = in_word_i[14:8];
        want.alive = 1'b0;
        case (want.func)
          tlg_pkg::FUNC_WRITE: grid_q[want.row][want.col] = in_word_i[15];
          tlg_pkg::FUNC_READ:  want.alive = grid_q[want.row][want.col];
          tlg_pkg::FUNC_STEP:  evolve_grid();
          default: ;
        endcase
        alive_expected_q.push_back(want);
      end
      outstanding_o <= alive_expected_q.size();
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top of the toroidal Life grid engine: clock, reset, input and area-register
// stimulus, result back-pressure, a watchdog and the verdict.
// Depends on tlg_pkg, the engine RTL and tlg_grid_checker.
module tb_top;

  // Func code 3 has no name in the package; the block must answer it with a dead cell.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_GAP     = 16;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 80;
  // No word may go unmoved this long: a full-grid generation plus the longest
  // stall on both sides is well under a fifth of it.
  localparam int IDLE_LIMIT  = 3000;
  localparam int N_PHASES    = 12;
  localparam int HOLD_PHASE  = 8;
  localparam int RANDOM_FROM = 9;

  // Area settings per phase: the extremes of both registers, a zero that acts as one,
  // values above storage that clamp, single rows and columns, and small dense grids.
  // The last phases draw their settings at random.
  localparam int PLAN_ROWS [N_PHASES]   = '{40, 0, 1, 64, 127, 3, 2, 5, 8, 0, 0, 0};
  localparam int PLAN_COLS [N_PHASES]   = '{120, 0, 128, 1, 255, 3, 2, 7, 16, 0, 0, 0};
  localparam int PLAN_WORDS [N_PHASES]  = '{150, 80, 120, 120, 150, 150, 100, 150, 200,
                                            150, 150, 120};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // From bit 0: func, cell_row, cell_col, cell_value.
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // From bit 0: cell_alive, zero fill.
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  int mismatch_count;
  int outstanding;

  // Shared between the sender and the receiver: a phase without any idling, and a
  // request for one long result stall.
  bit no_gaps;
  bit long_hold_req;

  int words_sent;
  int steps_sent;
  int reads_sent;
  int area_rows;
  int area_cols;

  always #4 clk_i = ~clk_i;

  toroidal_life_grid_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tlg_grid_checker u_grid_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_word_i        (s_axis_tdata),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_word_i       (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Effective area size, used only to aim the patterns at cells inside the area.
  function automatic int area_span(int raw, int storage);
    if (raw == 0) return 1;
    if (raw > storage) return storage;
    return raw;
  endfunction

  // A coordinate within two steps of base, wrapped inside span.
  function automatic logic [6:0] nearby_coord(int base, int span);
    return 7'((base + span * 2 + $urandom_range(0, 4) - 2) % span);
  endfunction

  // Offers one input word after a random gap and returns at the falling edge after it
  // was taken. With no gap, tvalid simply stays high into the next word.
  task automatic send_word(logic [1:0] func, logic [5:0] row, logic [6:0] col,
                           logic value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, col, row, func};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
    if (func == tlg_pkg::FUNC_STEP) steps_sent++;
    if (func == tlg_pkg::FUNC_READ) reads_sent++;
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last register.
  task automatic put_register(logic index, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Result side: a random stall before each word, or one long stall on request while
  // the sender keeps going, so the block fills up and holds off its input.
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (long_hold_req) begin
        gap = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int p, k, n, first_word, r0, c0, rspan, cspan;
    logic [7:0] rows_raw, cols_raw;
    bit off_area;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = tlg_pkg::CFG_ROWS;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    long_hold_req = 1'b0;
    words_sent    = 0;
    steps_sent    = 0;
    reads_sent    = 0;
    area_rows     = 40;
    area_cols     = 120;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the reset area of 40 by 120. A fresh grid reads dead, the last
    // storage cell lies outside the area and must survive generations untouched, and a
    // blinker straddling the column wrap flips across the row wrap and back.
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_WRITE, 6'd0, 7'd0, 1'b1);
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd0, 1'b1);
    send_word(tlg_pkg::FUNC_WRITE, 6'd63, 7'd127, 1'b1);
    send_word(tlg_pkg::FUNC_READ, 6'd63, 7'd127, 1'b0);
    send_word(tlg_pkg::FUNC_WRITE, 6'd0, 7'd119, 1'b1);
    send_word(tlg_pkg::FUNC_WRITE, 6'd0, 7'd1, 1'b1);
    send_word(tlg_pkg::FUNC_STEP, 6'd63, 7'd127, 1'b1);
    send_word(tlg_pkg::FUNC_READ, 6'd39, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd1, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd1, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd119, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd63, 7'd127, 1'b0);
    // The unused code with every other bit set must change nothing.
    send_word(FUNC_UNUSED, 6'd63, 7'd127, 1'b1);
    send_word(tlg_pkg::FUNC_READ, 6'd39, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_STEP, 6'd0, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd0, 7'd119, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd39, 7'd0, 1'b0);
    send_word(tlg_pkg::FUNC_WRITE, 6'd63, 7'd127, 1'b0);
    send_word(tlg_pkg::FUNC_READ, 6'd63, 7'd127, 1'b0);

    for (p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) begin
        rows_raw = 8'($urandom_range(0, 127));
        cols_raw = 8'($urandom_range(0, 255));
      end else if (p >= RANDOM_FROM) begin
        rows_raw = 8'($urandom_range(1, 24));
        cols_raw = 8'($urandom_range(1, 40));
      end else begin
        rows_raw = 8'(PLAN_ROWS[p]);
        cols_raw = 8'(PLAN_COLS[p]);
      end

      // The area only changes while the block is idle: every result word is back
      // before the registers are written.
      s_axis_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      put_register(tlg_pkg::CFG_ROWS, rows_raw);
      put_register(tlg_pkg::CFG_COLS, cols_raw);
      cfg_valid_i <= 1'b0;
      area_rows = area_span(int'(rows_raw[tlg_pkg::ROWS_CFG_W-1:0]), tlg_pkg::ROWS);
      area_cols = area_span(int'(cols_raw), tlg_pkg::COLS);

      no_gaps = ($urandom_range(0, 3) == 0);
      if (p == HOLD_PHASE) begin
        no_gaps       = 1'b1;
        long_hold_req = 1'b1;
      end

      // Mostly seed-evolve-probe patterns: a cluster of writes around one cell, one to
      // three generations, then reads around the same cell. Now and then the cluster
      // sits outside the area, and a fifth of the time a fully random word is sent.
      first_word = words_sent;
      while (words_sent - first_word < PLAN_WORDS[p]) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(2'($urandom_range(0, 3)), 6'($urandom), 7'($urandom), 1'($urandom));
        end else begin
          off_area = ($urandom_range(0, 7) == 0);
          rspan = off_area ? tlg_pkg::ROWS : area_rows;
          cspan = off_area ? tlg_pkg::COLS : area_cols;
          r0 = $urandom_range(0, rspan - 1);
          c0 = $urandom_range(0, cspan - 1);
          n = $urandom_range(2, 8);
          for (k = 0; k < n; k++) begin
            send_word(tlg_pkg::FUNC_WRITE, 6'(nearby_coord(r0, rspan)),
                      nearby_coord(c0, cspan), 1'($urandom_range(0, 3) != 0));
          end
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) begin
            send_word(tlg_pkg::FUNC_STEP, 6'($urandom), 7'($urandom), 1'($urandom));
          end
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            send_word(tlg_pkg::FUNC_READ, 6'(nearby_coord(r0, rspan)),
                      nearby_coord(c0, cspan), 1'($urandom));
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d input words (%0d generations, %0d cell reads) over %0d area settings,",
             words_sent, steps_sent, reads_sent, N_PHASES);
    $display("with clamped and single-row or single-column areas and one long result stall.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tlg_pkg.sv
rtl/core/tlg_ram.sv
rtl/core/tlg_cell.sv
rtl/core/toroidal_life_grid_engine.sv
test/tlg_grid_checker.sv
test/tb_top.sv
